>>> hdl/pdwm_pkg.sv
// ----------------------------------------------------------------------------
// pdwm_pkg: shared types and constants for the deformation window max core
// Holds the field widths, the Q16.16 limits, the register map and the
// structs that pass between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package pdwm_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned OFF_W   = 4;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned Q_W     = 32;
  localparam int unsigned COEF_W  = 24;
  localparam int unsigned CMP_W   = 13;  // wide enough for a map dimension up to 8191
  localparam int unsigned PADDR_W = 4;

  // Q16.16 saturation limits.
  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_QUAD_X = 2'd0;
  localparam logic [1:0] REG_LIN_X  = 2'd1;
  localparam logic [1:0] REG_QUAD_Y = 2'd2;
  localparam logic [1:0] REG_LIN_Y  = 2'd3;

  // Queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // Deformation coefficients, each a signed Q8.16 value.
  typedef struct packed {
    logic [COEF_W-1:0] quad_x;
    logic [COEF_W-1:0] lin_x;
    logic [COEF_W-1:0] quad_y;
    logic [COEF_W-1:0] lin_y;
  } pdwm_cfg_t;

  // One classified position as it waits in the queue.
  typedef struct packed {
    logic [Q_W-1:0]   score;
    logic [Q_W-1:0]   cost;
    logic             take;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             last;
  } pdwm_entry_t;

  // Queue fill status seen by both ends.
  typedef struct packed {
    logic empty;
    logic full;
  } pdwm_qstat_t;

endpackage

>>> hdl/pdwm_front.sv
// ----------------------------------------------------------------------------
// pdwm_front: input stage and position classifier
// Clamps the offsets, forms the deformation products, then sums and
// saturates the cost and decides whether the position takes part.
// ----------------------------------------------------------------------------
module pdwm_front
  import pdwm_pkg::*;
#(
  parameter int unsigned HALF_WINDOW = 5,
  parameter int unsigned MAP_DIM     = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pdwm_cfg_t        cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OFF_W-1:0] offset_x_i,
  input  logic [OFF_W-1:0] offset_y_i,
  input  logic [POS_W-1:0] pos_x_i,
  input  logic [POS_W-1:0] pos_y_i,
  input  logic [Q_W-1:0]   filter_score_i,
  input  logic             score_cached_i,
  input  logic [Q_W-1:0]   prune_threshold_i,
  input  logic             last_position_i,
  input  pdwm_qstat_t      qstat_i,
  output logic             push_o,
  output pdwm_entry_t      entry_o
);

  localparam logic signed [5:0] HalfW = 6'(HALF_WINDOW);
  localparam logic [CMP_W-1:0]  MapLim = CMP_W'(MAP_DIM);

  // Offset clamping to the half window.
  logic signed [5:0]       dx_w, dy_w;
  logic signed [OFF_W-1:0] dx_c, dy_c;
  logic signed [7:0]       dx_sq, dy_sq;

  assign dx_w = {{2{offset_x_i[OFF_W-1]}}, offset_x_i};
  assign dy_w = {{2{offset_y_i[OFF_W-1]}}, offset_y_i};

  always_comb begin
    if (dx_w > HalfW) begin
      dx_c = OFF_W'(HalfW);
    end else if (dx_w < -HalfW) begin
      dx_c = OFF_W'(-HalfW);
    end else begin
      dx_c = dx_w[OFF_W-1:0];
    end
    if (dy_w > HalfW) begin
      dy_c = OFF_W'(HalfW);
    end else if (dy_w < -HalfW) begin
      dy_c = OFF_W'(-HalfW);
    end else begin
      dy_c = dy_w[OFF_W-1:0];
    end
  end

  assign dx_sq = dx_c * dx_c;
  assign dy_sq = dy_c * dy_c;

  // Deformation products, one small multiplier each.
  logic signed [31:0] prod_qx, prod_qy;
  logic signed [27:0] prod_lx, prod_ly;

  assign prod_qx = $signed(cfg_i.quad_x) * dx_sq;
  assign prod_lx = $signed(cfg_i.lin_x) * dx_c;
  assign prod_qy = $signed(cfg_i.quad_y) * dy_sq;
  assign prod_ly = $signed(cfg_i.lin_y) * dy_c;

  // Stage A holds the products and the pass-through fields.
  logic               a_valid_q, a_valid_d;
  logic signed [31:0] a_qx_q, a_qy_q;
  logic signed [27:0] a_lx_q, a_ly_q;
  logic [Q_W-1:0]     a_score_q;
  logic signed [Q_W-1:0] a_thresh_q;
  logic               a_cached_q;
  logic               a_in_map_q;
  logic [POS_W-1:0]   a_pos_x_q, a_pos_y_q;
  logic               a_last_q;
  logic               load;
  logic               in_map;

  assign in_stall_o = a_valid_q & qstat_i.full;
  assign load       = in_valid_i & ~in_stall_o;
  assign push_o     = a_valid_q & ~qstat_i.full;
  assign in_map     = (CMP_W'(pos_x_i) < MapLim) && (CMP_W'(pos_y_i) < MapLim);

  always_comb begin
    a_valid_d = a_valid_q;
    if (load) begin
      a_valid_d = 1'b1;
    end else if (push_o) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      a_qx_q     <= prod_qx;
      a_lx_q     <= prod_lx;
      a_qy_q     <= prod_qy;
      a_ly_q     <= prod_ly;
      a_score_q  <= filter_score_i;
      a_thresh_q <= prune_threshold_i;
      a_cached_q <= score_cached_i;
      a_in_map_q <= in_map;
      a_pos_x_q  <= pos_x_i;
      a_pos_y_q  <= pos_y_i;
      a_last_q   <= last_position_i;
    end
  end

  // Cost sum with one saturation, then the pruning decision.
  logic signed [33:0] t_qx, t_lx, t_qy, t_ly, cost_full;
  logic signed [Q_W-1:0] cost_sat;

  assign t_qx      = {{2{a_qx_q[31]}}, a_qx_q};
  assign t_lx      = {{6{a_lx_q[27]}}, a_lx_q};
  assign t_qy      = {{2{a_qy_q[31]}}, a_qy_q};
  assign t_ly      = {{6{a_ly_q[27]}}, a_ly_q};
  assign cost_full = -t_qx - t_lx - t_qy - t_ly;

  always_comb begin
    if (cost_full[33:31] == 3'b000 || cost_full[33:31] == 3'b111) begin
      cost_sat = cost_full[Q_W-1:0];
    end else if (cost_full[33]) begin
      cost_sat = Q_MIN;
    end else begin
      cost_sat = Q_MAX;
    end
  end

  always_comb begin
    entry_o.score = a_score_q;
    entry_o.cost  = cost_sat;
    entry_o.take  = a_in_map_q & (a_cached_q | ~(cost_sat < a_thresh_q));
    entry_o.pos_x = a_pos_x_q;
    entry_o.pos_y = a_pos_y_q;
    entry_o.last  = a_last_q;
  end

endmodule

>>> hdl/pdwm_queue.sv
// ----------------------------------------------------------------------------
// pdwm_queue: short queue of classified positions
// Decouples the classifier from the running maximum so that either side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module pdwm_queue
  import pdwm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  pdwm_entry_t entry_i,
  input  logic        pop_i,
  output pdwm_entry_t head_o,
  output pdwm_qstat_t qstat_o
);

  pdwm_entry_t       mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push       = push_i & ~qstat_o.full;
  assign do_pop        = pop_i & ~qstat_o.empty;
  assign head_o        = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  // A full queue that is not popped keeps its fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qstat_o.full && !pop_i) |=> $stable(count_q))
    else $error("full queue changed without a pop");

endmodule

>>> hdl/pdwm_back.sv
// ----------------------------------------------------------------------------
// pdwm_back: running maximum and result register
// Takes classified positions from the queue, keeps the first strict
// maximum of score plus cost and hands the result out on the last one.
// ----------------------------------------------------------------------------
module pdwm_back
  import pdwm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pdwm_entry_t      head_i,
  input  pdwm_qstat_t      qstat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [Q_W-1:0]   best_score_o,
  output logic [POS_W-1:0] best_pos_x_o,
  output logic [POS_W-1:0] best_pos_y_o,
  output logic             found_o
);

  logic                  out_valid_q, out_valid_d;
  logic signed [Q_W-1:0] best_q, best_d;
  logic [POS_W-1:0]      best_x_q, best_x_d;
  logic [POS_W-1:0]      best_y_q, best_y_d;
  logic                  any_q, any_d;
  logic [Q_W-1:0]        res_score_q;
  logic [POS_W-1:0]      res_x_q, res_y_q;
  logic                  res_found_q;

  // A last item waits until the result register is free.
  assign pop_o = ~qstat_i.empty & (~head_i.last | ~out_valid_q | ~out_stall_i);

  // Saturating score plus cost.
  logic signed [Q_W:0]   val_full;
  logic signed [Q_W-1:0] val;
  logic                  better;

  assign val_full = $signed({head_i.score[Q_W-1], head_i.score})
                  + $signed({head_i.cost[Q_W-1], head_i.cost});

  always_comb begin
    if (val_full[Q_W] == val_full[Q_W-1]) begin
      val = val_full[Q_W-1:0];
    end else if (val_full[Q_W]) begin
      val = Q_MIN;
    end else begin
      val = Q_MAX;
    end
  end

  assign better = head_i.take & (~any_q | (val > best_q));

  // Running state: update on a better position, clear after a result.
  logic signed [Q_W-1:0] nb;
  logic [POS_W-1:0]      nx, ny;
  logic                  na;

  always_comb begin
    nb = better ? val          : best_q;
    nx = better ? head_i.pos_x : best_x_q;
    ny = better ? head_i.pos_y : best_y_q;
    na = better | any_q;
    best_d   = best_q;
    best_x_d = best_x_q;
    best_y_d = best_y_q;
    any_d    = any_q;
    if (pop_o) begin
      if (head_i.last) begin
        best_d   = Q_MIN;
        best_x_d = '0;
        best_y_d = '0;
        any_d    = 1'b0;
      end else begin
        best_d   = nb;
        best_x_d = nx;
        best_y_d = ny;
        any_d    = na;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (pop_o && head_i.last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      best_q      <= Q_MIN;
      best_x_q    <= '0;
      best_y_q    <= '0;
      any_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      best_q      <= best_d;
      best_x_q    <= best_x_d;
      best_y_q    <= best_y_d;
      any_q       <= any_d;
    end
  end

  // Result register, loaded with the state as it stands after the last item.
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.last) begin
      res_score_q <= nb;
      res_x_q     <= nx;
      res_y_q     <= ny;
      res_found_q <= na;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_score_o = res_score_q;
  assign best_pos_x_o = res_x_q;
  assign best_pos_y_o = res_y_q;
  assign found_o      = res_found_q;

  // A last item clears the running state and presents a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.last) |=> (!any_q && out_valid_q))
    else $error("last item did not close the window");

  // With nothing taken the running state sits at its cleared values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> (best_q == Q_MIN && best_x_q == '0 && best_y_q == '0))
    else $error("running state not clear while nothing taken");

  // A result without a position reports the most negative score.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (best_score_o == Q_MIN))
    else $error("empty window result carries a score");

endmodule

>>> hdl/pruned_deformation_window_max_core.sv
// ----------------------------------------------------------------------------
// pruned_deformation_window_max_core: pruned window maximum with deformation
// Top level: configuration registers, classifier, queue and running maximum.
// ----------------------------------------------------------------------------
// The core accepts one window position per clock cycle and sustains that rate
// for as long as results are taken. An accepted item is registered in the
// product stage, is summed, saturated and classified as it enters a queue of
// four entries, and is folded into the running maximum when the back end pops
// it; the single score compare of the back end, one entry per cycle, sets the
// throughput. The result of a window is held in an output register, so
// further items are accepted while it waits; a stalled result backs up into
// the queue and only when the queue and the product stage are full is the
// input stalled. The user must write the four coefficients through the
// APB-style port while the core is idle; the core does not enforce this.
// ----------------------------------------------------------------------------
module pruned_deformation_window_max_core
  import pdwm_pkg::*;
#(
  parameter int unsigned HALF_WINDOW = 5,
  parameter int unsigned MAP_DIM     = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OFF_W-1:0]   offset_x_i,
  input  logic [OFF_W-1:0]   offset_y_i,
  input  logic [POS_W-1:0]   pos_x_i,
  input  logic [POS_W-1:0]   pos_y_i,
  input  logic [Q_W-1:0]     filter_score_i,
  input  logic               score_cached_i,
  input  logic [Q_W-1:0]     prune_threshold_i,
  input  logic               last_position_i,
  // Result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [Q_W-1:0]     best_score_o,
  output logic [POS_W-1:0]   best_pos_x_o,
  output logic [POS_W-1:0]   best_pos_y_o,
  output logic               found_o
);

  // Coefficient registers.
  pdwm_cfg_t  cfg_q, cfg_d;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_QUAD_X: cfg_d.quad_x = pwdata[COEF_W-1:0];
        REG_LIN_X:  cfg_d.lin_x  = pwdata[COEF_W-1:0];
        REG_QUAD_Y: cfg_d.quad_y = pwdata[COEF_W-1:0];
        REG_LIN_Y:  cfg_d.lin_y  = pwdata[COEF_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back, sign-extended to the bus width.
  always_comb begin
    case (reg_idx)
      REG_QUAD_X: prdata = {{(32-COEF_W){cfg_q.quad_x[COEF_W-1]}}, cfg_q.quad_x};
      REG_LIN_X:  prdata = {{(32-COEF_W){cfg_q.lin_x[COEF_W-1]}}, cfg_q.lin_x};
      REG_QUAD_Y: prdata = {{(32-COEF_W){cfg_q.quad_y[COEF_W-1]}}, cfg_q.quad_y};
      REG_LIN_Y:  prdata = {{(32-COEF_W){cfg_q.lin_y[COEF_W-1]}}, cfg_q.lin_y};
      default:    prdata = '0;
    endcase
  end

  // Front end, queue and back end.
  pdwm_qstat_t qstat;
  pdwm_entry_t entry, head;
  logic        push, pop;

  pdwm_front #(
    .HALF_WINDOW (HALF_WINDOW),
    .MAP_DIM     (MAP_DIM)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .offset_x_i        (offset_x_i),
    .offset_y_i        (offset_y_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .filter_score_i    (filter_score_i),
    .score_cached_i    (score_cached_i),
    .prune_threshold_i (prune_threshold_i),
    .last_position_i   (last_position_i),
    .qstat_i           (qstat),
    .push_o            (push),
    .entry_o           (entry)
  );

  pdwm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  pdwm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .best_score_o (best_score_o),
    .best_pos_x_o (best_pos_x_o),
    .best_pos_y_o (best_pos_y_o),
    .found_o      (found_o)
  );

endmodule

>>> test/tb_pruned_deformation_window_max_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pruned_deformation_window_max_core: self-checking bench for the core
// Streams windows of positions through the core under several coefficient
// settings, predicts each window maximum in the bench and compares every
// result item field by field, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_pruned_deformation_window_max_core;
  import pdwm_pkg::*;

  localparam longint HALF_WIN      = 5;
  localparam longint MAP_LIMIT     = 256;
  localparam longint Q_HI          = 2147483647;
  localparam longint Q_LO          = -Q_HI - 1;
  localparam int     ITEMS_PER_SET = 60;
  localparam int     SETTLE_CYCLES = 8;

  // One window position as it is driven onto the input channel.
  typedef struct packed {
    logic [OFF_W-1:0] offset_x;
    logic [OFF_W-1:0] offset_y;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [Q_W-1:0]   filter_score;
    logic             score_cached;
    logic [Q_W-1:0]   prune_threshold;
    logic             last_position;
  } position_t;

  // One window maximum as it leaves the core.
  typedef struct packed {
    logic [Q_W-1:0]   best_score;
    logic [POS_W-1:0] best_pos_x;
    logic [POS_W-1:0] best_pos_y;
    logic             found;
  } window_best_t;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               psel              = 1'b0;
  logic               penable           = 1'b0;
  logic               pwrite            = 1'b0;
  logic [PADDR_W-1:0] paddr             = '0;
  logic [31:0]        pwdata            = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               out_stall_i       = 1'b0;
  logic [Q_W-1:0]     best_score_o;
  logic [POS_W-1:0]   best_pos_x_o;
  logic [POS_W-1:0]   best_pos_y_o;
  logic               found_o;
  position_t          drv_pos           = '0;

  // Bench copy of the coefficients and the running window maximum.
  longint             coef[4];
  longint             run_best;
  logic [POS_W-1:0]   run_best_x;
  logic [POS_W-1:0]   run_best_y;
  bit                 any_taken;

  position_t          position_q[$];
  window_best_t       window_best_q[$];
  int                 mismatch_count    = 0;
  bit                 calm              = 1'b1;
  int                 calm_left         = 0;

  pruned_deformation_window_max_core #(
    .HALF_WINDOW (5),
    .MAP_DIM     (256)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .offset_x_i        (drv_pos.offset_x),
    .offset_y_i        (drv_pos.offset_y),
    .pos_x_i           (drv_pos.pos_x),
    .pos_y_i           (drv_pos.pos_y),
    .filter_score_i    (drv_pos.filter_score),
    .score_cached_i    (drv_pos.score_cached),
    .prune_threshold_i (drv_pos.prune_threshold),
    .last_position_i   (drv_pos.last_position),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .best_score_o      (best_score_o),
    .best_pos_x_o      (best_pos_x_o),
    .best_pos_y_o      (best_pos_y_o),
    .found_o           (found_o)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Overall time limit for the run.
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Alternate between stretches with random idling and calm stretches without.
  always @(posedge clk_i) begin
    if (calm_left == 0) begin
      calm_left <= $urandom_range(40, 400);
      calm      <= !calm;
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 33);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic longint saturate_q(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  function automatic longint clamp_offset(input logic [OFF_W-1:0] raw);
    longint d;
    d = longint'($signed(raw));
    if (d > HALF_WIN) d = HALF_WIN;
    else if (d < -HALF_WIN) d = -HALF_WIN;
    return d;
  endfunction

  function automatic void clear_window();
    run_best   = Q_LO;
    run_best_x = '0;
    run_best_y = '0;
    any_taken  = 1'b0;
  endfunction

  // Folds one accepted position into the window maximum; returns 1 and the
  // maximum when the position closes its window.
  function automatic bit fold_position(input position_t p, output window_best_t r);
    longint dx;
    longint dy;
    longint cost;
    longint val;
    bit     take;
    dx   = clamp_offset(p.offset_x);
    dy   = clamp_offset(p.offset_y);
    cost = saturate_q(-(coef[REG_QUAD_X] * dx * dx) - coef[REG_LIN_X] * dx
                      - (coef[REG_QUAD_Y] * dy * dy) - coef[REG_LIN_Y] * dy);
    take = (longint'(p.pos_x) < MAP_LIMIT) && (longint'(p.pos_y) < MAP_LIMIT);
    if (!p.score_cached && cost < longint'($signed(p.prune_threshold))) take = 1'b0;
    if (take) begin
      val = saturate_q(longint'($signed(p.filter_score)) + cost);
      // The first candidate always wins; later ones must be strictly greater.
      if (!any_taken || val > run_best) begin
        run_best   = val;
        run_best_x = p.pos_x;
        run_best_y = p.pos_y;
        any_taken  = 1'b1;
      end
    end
    r = '0;
    if (!p.last_position) return 1'b0;
    r.best_score = run_best[Q_W-1:0];
    r.best_pos_x = run_best_x;
    r.best_pos_y = run_best_y;
    r.found      = any_taken;
    clear_window();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // ---------------------------------------------------------------- driver

  // Presents the next pending item once the current one has been accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (position_q.size() != 0 && !take_break()) begin
        drv_pos    <= position_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  // Predicts on every accepted item and checks every accepted result item.
  always @(posedge clk_i) begin
    window_best_t pred;
    window_best_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= take_break();
      if (in_valid_i && !in_stall_o) begin
        if (fold_position(drv_pos, pred)) window_best_q = {window_best_q, pred};
      end
      if (out_valid_o && !out_stall_i) begin
        if (window_best_q.size() == 0) begin
          report_mismatch("result item with no window pending");
        end else begin
          want = window_best_q.pop_front();
          check_field("best_score", best_score_o, want.best_score);
          check_field("best_pos_x", 32'(best_pos_x_o), 32'(want.best_pos_x));
          check_field("best_pos_y", 32'(best_pos_y_o), 32'(want.best_pos_y));
          check_field("found", 32'(found_o), 32'(want.found));
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic position_t mk_pos(input logic [OFF_W-1:0] ox, input logic [OFF_W-1:0] oy,
                                       input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                                       input logic [Q_W-1:0] score, input logic cached,
                                       input logic [Q_W-1:0] thr, input logic last);
    position_t p;
    p.offset_x        = ox;
    p.offset_y        = oy;
    p.pos_x           = px;
    p.pos_y           = py;
    p.filter_score    = score;
    p.score_cached    = cached;
    p.prune_threshold = thr;
    p.last_position   = last;
    return p;
  endfunction

  // Appends one item to the pending items of the driver.
  task automatic enqueue_position(input position_t p);
    position_q = {position_q, p};
  endtask

  function automatic logic [Q_W-1:0] pick_small_score();
    case ($urandom_range(0, 2))
      0:       return 32'hFFFF_0000;
      1:       return 32'h0000_0000;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [Q_W-1:0] pick_score();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return Q_MAX;
    if (r < 6) return Q_MIN;
    if (r < 10) return pick_small_score();
    return $urandom;
  endfunction

  function automatic logic [Q_W-1:0] pick_threshold();
    int r;
    r = $urandom_range(0, 19);
    if (r < 5) return Q_MIN;
    if (r < 7) return Q_MAX;
    // Two in five thresholds fall within the reach of the deformation cost.
    if (r < 15) return 32'($signed($urandom) >>> 2);
    return $urandom;
  endfunction

  // Queues one window of n positions. Kinds: 0 random content, 1 small cached
  // scores at one offset, 2 every position uncached at the top threshold.
  task automatic queue_window(input int kind, input int n);
    position_t        p;
    logic [OFF_W-1:0] ox;
    logic [OFF_W-1:0] oy;
    ox = OFF_W'($urandom_range(0, 15));
    oy = OFF_W'($urandom_range(0, 15));
    for (int i = 0; i < n; i++) begin
      p = mk_pos(OFF_W'($urandom_range(0, 15)), OFF_W'($urandom_range(0, 15)),
                 POS_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 255)),
                 pick_score(), 1'($urandom_range(0, 1)),
                 pick_threshold(), (i == n - 1));
      if (kind == 1) begin
        p.offset_x     = ox;
        p.offset_y     = oy;
        p.filter_score = pick_small_score();
        p.score_cached = 1'b1;
      end else if (kind == 2) begin
        p.score_cached    = 1'b0;
        p.prune_threshold = Q_MAX;
      end
      enqueue_position(p);
    end
  endtask

  task automatic queue_random_windows(input int target);
    int added;
    int r;
    int n;
    added = 0;
    while (added < target) begin
      r = $urandom_range(0, 19);
      n = $urandom_range(1, 12);
      if (r < 12) queue_window(0, n);
      else if (r < 15) queue_window(1, n);
      else if (r < 17) queue_window(2, n);
      else begin
        n = 1;
        queue_window(0, n);
      end
      added += n;
    end
  endtask

  // Waits until every item is accepted and every result has arrived, then
  // lets the pipeline empty.
  task automatic settle();
    while (position_q.size() != 0 || in_valid_i || window_best_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write: setup phase, then access phase until pready.
  task automatic write_coef(input logic [1:0] idx, input logic [COEF_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    // The upper byte is noise; only the low 24 bits are kept.
    pwdata  <= {8'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    coef[idx] = longint'($signed(val));
  endtask

  task automatic load_coefficients(input logic [COEF_W-1:0] qx, input logic [COEF_W-1:0] lx,
                                   input logic [COEF_W-1:0] qy, input logic [COEF_W-1:0] ly);
    write_coef(REG_QUAD_X, qx);
    write_coef(REG_LIN_X, lx);
    write_coef(REG_QUAD_Y, qy);
    write_coef(REG_LIN_Y, ly);
  endtask

  function automatic logic [COEF_W-1:0] small_coef();
    return COEF_W'($urandom_range(0, 2 ** 19 - 1) - 2 ** 18);
  endfunction

  // ---------------------------------------------------------------- sequence

  initial begin
    for (int i = 0; i < 4; i++) coef[i] = 0;
    clear_window();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        1: load_coefficients(24'h800000, 24'h800000, 24'h800000, 24'h800000);
        2: load_coefficients(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        3: load_coefficients(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
        4: load_coefficients(COEF_W'($urandom), COEF_W'($urandom),
                             COEF_W'($urandom), COEF_W'($urandom));
        5: load_coefficients(small_coef(), small_coef(), small_coef(), small_coef());
        6: load_coefficients('0, '0, '0, '0);
        default: ;
      endcase

      if (phase == 0) begin
        // Zero cost. A window where nothing is taken.
        enqueue_position(mk_pos(4'h0, 4'h0, 8'd3, 8'd4, 32'd7, 1'b0, Q_MAX, 1'b1));
        // The first candidate is taken even at the most negative value.
        enqueue_position(mk_pos(4'h0, 4'h0, 8'd10, 8'd20, Q_MIN, 1'b1, Q_MIN, 1'b0));
        enqueue_position(mk_pos(4'h0, 4'h0, 8'd30, 8'd40, Q_MIN, 1'b1, Q_MIN, 1'b1));
        // A tie keeps the earlier position.
        enqueue_position(mk_pos(4'h1, 4'h2, 8'd1, 8'd1, 32'd100, 1'b1, Q_MIN, 1'b0));
        enqueue_position(mk_pos(4'h1, 4'h2, 8'd2, 8'd2, 32'd100, 1'b1, Q_MIN, 1'b0));
        enqueue_position(mk_pos(4'h1, 4'h2, 8'd3, 8'd3, 32'd50, 1'b1, Q_MIN, 1'b1));
        // Field extremes, offsets outside the half window.
        enqueue_position(mk_pos(4'h8, 4'h7, 8'd255, 8'd255, Q_MAX, 1'b0, Q_MIN, 1'b0));
        enqueue_position(mk_pos(4'h7, 4'h8, 8'd0, 8'd0, Q_MIN, 1'b1, Q_MAX, 1'b1));
        // An uncached position is pruned; a cached one below the threshold is not.
        enqueue_position(mk_pos(4'h0, 4'h0, 8'd9, 8'd9, Q_MAX, 1'b0, 32'd1, 1'b0));
        enqueue_position(mk_pos(4'h0, 4'h0, 8'd8, 8'd8, 32'd5, 1'b1, Q_MAX, 1'b1));
      end else if (phase == 1) begin
        // Large positive cost: the sum saturates high.
        enqueue_position(mk_pos(4'h5, 4'h5, 8'd11, 8'd12, Q_MAX, 1'b1, Q_MAX, 1'b1));
        enqueue_position(mk_pos(4'h8, 4'hB, 8'd13, 8'd14, 32'd0, 1'b0, Q_MIN, 1'b0));
        enqueue_position(mk_pos(4'h7, 4'h7, 8'd15, 8'd16, 32'd0, 1'b0, Q_MIN, 1'b1));
      end else if (phase == 2) begin
        // Large negative cost: the sum saturates low, and pruning bites.
        enqueue_position(mk_pos(4'h5, 4'h5, 8'd21, 8'd22, Q_MIN, 1'b1, Q_MAX, 1'b1));
        enqueue_position(mk_pos(4'h1, 4'h1, 8'd23, 8'd24, Q_MAX, 1'b0, 32'd0, 1'b0));
        enqueue_position(mk_pos(4'hB, 4'hB, 8'd25, 8'd26, 32'd0, 1'b1, 32'd0, 1'b1));
      end

      queue_random_windows(ITEMS_PER_SET);
      settle();
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> pruned_deformation_window_max_core.f
hdl/pdwm_pkg.sv
hdl/pdwm_front.sv
hdl/pdwm_queue.sv
hdl/pdwm_back.sv
hdl/pruned_deformation_window_max_core.sv
test/tb_pruned_deformation_window_max_core.sv
